// File: hdl/fca_pkg.sv
// Package for the flagged channel averager.
// Holds register defaults, register indexes, state codes and lane control type.
// No dependencies.
package fca_pkg;

  localparam int DEF_MAX_POLS     = 4;
  localparam int DEF_MAX_STEP     = 256;
  localparam int DEF_MAX_CHANNELS = 4096;
  localparam int DEF_SAMPLE_BITS  = 16;

  localparam int NUM_FIELDS   = 4;   // sample fields carried by one transaction
  localparam int WEIGHT_W     = 16;
  localparam int POL_IDX_W    = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int NUM_POLS_W   = 3;
  localparam int FIRST_CH_W   = 12;
  localparam int CH_COUNT_W   = 13;
  localparam int SPEC_LEN_W   = 13;
  localparam int STEP_W       = 9;

  localparam logic [NUM_POLS_W-1:0] RST_NUM_POLS = 3'd4;
  localparam logic [FIRST_CH_W-1:0] RST_FIRST_CH = 12'd0;
  localparam logic [CH_COUNT_W-1:0] RST_CH_COUNT = 13'd4096;
  localparam logic [SPEC_LEN_W-1:0] RST_SPEC_LEN = 13'd4096;
  localparam logic [STEP_W-1:0]     RST_STEP     = 9'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_POLS = 3'd0,
    REG_FIRST_CH = 3'd1,
    REG_CH_COUNT = 3'd2,
    REG_SPEC_LEN = 3'd3,
    REG_STEP     = 3'd4
  } fca_reg_t;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_EMIT
  } fca_state_t;

  typedef struct packed {
    logic acc;       // add this transaction's good sample
    logic load;      // group complete: start divide, clear sums
    logic clear;     // drop partial group
    logic div_step;  // advance dividers one bit
  } fca_lane_ctl_t;

endpackage

// File: hdl/fca_if.sv
// Channel interfaces of the flagged channel averager.
// Depends on fca_pkg for default widths.
interface fca_in_if
  import fca_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] re_0, re_1, re_2, re_3;
  logic signed [SAMPLE_BITS-1:0] im_0, im_1, im_2, im_3;
  logic                          bad_0, bad_1, bad_2, bad_3;

  modport source (output valid, re_0, re_1, re_2, re_3, im_0, im_1, im_2, im_3,
                  bad_0, bad_1, bad_2, bad_3, input ready);
  modport sink   (input valid, re_0, re_1, re_2, re_3, im_0, im_1, im_2, im_3,
                  bad_0, bad_1, bad_2, bad_3, output ready);
endinterface

interface fca_out_if
  import fca_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic [POL_IDX_W-1:0]          pol_index;
  logic signed [SAMPLE_BITS-1:0] mean_re;
  logic signed [SAMPLE_BITS-1:0] mean_im;
  logic [WEIGHT_W-1:0]           weight;
  logic                          group_flagged;
  logic                          last_of_group;

  modport source (output valid, pol_index, mean_re, mean_im, weight, group_flagged,
                  last_of_group, input ready);
  modport sink   (input valid, pol_index, mean_re, mean_im, weight, group_flagged,
                  last_of_group, output ready);
endinterface

// File: hdl/flagged_channel_averager.sv
// Flagged channel averager: lanes per polarisation plus merging output stage.
// Depends on fca_pkg, fca_if (fca_in_if, fca_out_if) and fca_lane.
//
// Usage:
//   in_if  : one spectrum channel per transaction, four complex samples with
//            a bad flag each. ready is high while the lanes accumulate.
//   out_if : one transaction per active polarisation when a group of step
//            window channels is complete, in lane order; last_of_group marks
//            the final one. group_flagged is shared by the whole group.
//   cfg_*  : write port, index 0..4 = num_pols, first_channel, channel_count,
//            spectrum_length, step. Write only while the block is idle.
// Timing: channels that do not close a group are taken at one per cycle. One that
//   closes a group starts the lane dividers, which produce one quotient bit per
//   cycle; the results then leave at one per cycle while the receiver is ready.
// Reset: synchronous, active low; registers take their defaults, sums clear.
// A stalled receiver holds the current result; input stays blocked until the
//   last result of the group has been taken.
module flagged_channel_averager
  import fca_pkg::*;
#(
  parameter int MAX_POLS     = DEF_MAX_POLS,
  parameter int MAX_STEP     = DEF_MAX_STEP,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fca_in_if.sink                in_if,
  fca_out_if.source             out_if
);
  localparam int GCW   = $clog2(MAX_STEP + 1);
  localparam int GPW   = $clog2(MAX_STEP);
  localparam int CNT_W = $clog2(MAX_CHANNELS);
  localparam int LW    = (CNT_W + 1 > CH_COUNT_W + 1) ? CNT_W + 1 : CH_COUNT_W + 1;
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_STEP);
  localparam int NW    = (SUM_W > GCW + WEIGHT_W) ? SUM_W : GCW + WEIGHT_W;
  localparam int DCW   = $clog2(NW + 1);
  localparam int PIW   = (MAX_POLS > 1) ? $clog2(MAX_POLS) : 1;

  // Configuration registers
  logic [NUM_POLS_W-1:0] num_pols_r;
  logic [FIRST_CH_W-1:0] first_ch_r;
  logic [CH_COUNT_W-1:0] ch_count_r;
  logic [SPEC_LEN_W-1:0] spec_len_r;
  logic [STEP_W-1:0]     step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_pols_r <= RST_NUM_POLS;
      first_ch_r <= RST_FIRST_CH;
      ch_count_r <= RST_CH_COUNT;
      spec_len_r <= RST_SPEC_LEN;
      step_r     <= RST_STEP;
    end else if (cfg_we) begin
      case (fca_reg_t'(cfg_index))
        REG_NUM_POLS: num_pols_r <= cfg_data[NUM_POLS_W-1:0];
        REG_FIRST_CH: first_ch_r <= cfg_data[FIRST_CH_W-1:0];
        REG_CH_COUNT: ch_count_r <= cfg_data[CH_COUNT_W-1:0];
        REG_SPEC_LEN: spec_len_r <= cfg_data[SPEC_LEN_W-1:0];
        REG_STEP:     step_r     <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers to the supported ranges
  logic [NUM_POLS_W-1:0] np;
  logic [GCW-1:0]        st;
  logic [LW-1:0]         len, end_raw, win_end, c_ext, first_ext;

  always_comb begin
    if (num_pols_r == '0)              np = NUM_POLS_W'(1);
    else if (32'(num_pols_r) > MAX_POLS) np = NUM_POLS_W'(MAX_POLS);
    else                               np = num_pols_r;

    if (step_r == '0)                  st = GCW'(1);
    else if (32'(step_r) > MAX_STEP)   st = GCW'(MAX_STEP);
    else                               st = GCW'(step_r);

    if (spec_len_r == '0)                  len = LW'(1);
    else if (32'(spec_len_r) > MAX_CHANNELS) len = LW'(MAX_CHANNELS);
    else                                   len = LW'(spec_len_r);

    first_ext = LW'(first_ch_r);
    end_raw   = first_ext + LW'(ch_count_r);
    win_end   = (end_raw > len) ? len : end_raw;
  end

  // Control state
  fca_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]      chan_r, chan_nxt;
  logic [GPW-1:0]        gpos_r, gpos_nxt;
  logic                  all_bad_r, all_bad_nxt;
  logic                  grp_flag_r, grp_flag_nxt;
  logic [NUM_POLS_W-1:0] np_r, np_nxt;
  logic [DCW-1:0]        dcnt_r, dcnt_nxt;
  logic [PIW-1:0]        pidx_r, pidx_nxt;
  fca_lane_ctl_t         ctl;

  logic                  in_acc, out_acc, in_win, grp_done, win_last, any_good;
  logic [NUM_FIELDS-1:0] bad_v;
  logic [MAX_POLS-1:0]   en_mask;

  assign bad_v = {in_if.bad_3, in_if.bad_2, in_if.bad_1, in_if.bad_0};

  always_comb begin
    for (int p = 0; p < MAX_POLS; p++) en_mask[p] = (p < 32'(np));
  end

  assign c_ext    = LW'(chan_r);
  assign in_win   = (c_ext >= first_ext) && (c_ext < win_end);
  assign grp_done = (32'(gpos_r) + 1 >= 32'(st));
  assign win_last = (c_ext + LW'(1) == win_end);
  assign any_good = |(en_mask & ~bad_v[MAX_POLS-1:0]);

  assign in_if.ready  = (state_r == ST_ACC);
  assign out_if.valid = (state_r == ST_EMIT);
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_acc      = out_if.valid && out_if.ready;

  always_comb begin
    state_nxt    = state_r;
    chan_nxt     = chan_r;
    gpos_nxt     = gpos_r;
    all_bad_nxt  = all_bad_r;
    grp_flag_nxt = grp_flag_r;
    np_nxt       = np_r;
    dcnt_nxt     = dcnt_r;
    pidx_nxt     = pidx_r;
    ctl          = '0;
    case (state_r)
      ST_ACC: begin
        if (in_acc) begin
          // Advance the channel counter, wrapping at the spectrum end
          chan_nxt = (c_ext + LW'(1) >= len) ? '0 : CNT_W'(chan_r + CNT_W'(1));
          if (!in_win) begin
            ctl.clear   = 1'b1;
            gpos_nxt    = '0;
            all_bad_nxt = 1'b1;
          end else begin
            ctl.acc = 1'b1;
            if (grp_done) begin
              ctl.load     = 1'b1;
              grp_flag_nxt = all_bad_r && !any_good;
              np_nxt       = np;
              gpos_nxt     = '0;
              all_bad_nxt  = 1'b1;
              dcnt_nxt     = '0;
              state_nxt    = ST_DIV;
            end else if (win_last) begin
              // Drop a partial group at the window end
              ctl.clear   = 1'b1;
              gpos_nxt    = '0;
              all_bad_nxt = 1'b1;
            end else begin
              gpos_nxt    = gpos_r + GPW'(1);
              all_bad_nxt = all_bad_r && !any_good;
            end
          end
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(NW - 1)) begin
          pidx_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (32'(pidx_r) + 1 == 32'(np_r)) state_nxt = ST_ACC;
          else                             pidx_nxt  = pidx_r + PIW'(1);
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_ACC;
      chan_r     <= '0;
      gpos_r     <= '0;
      all_bad_r  <= 1'b1;
      grp_flag_r <= 1'b0;
      np_r       <= RST_NUM_POLS;
      dcnt_r     <= '0;
      pidx_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      chan_r     <= chan_nxt;
      gpos_r     <= gpos_nxt;
      all_bad_r  <= all_bad_nxt;
      grp_flag_r <= grp_flag_nxt;
      np_r       <= np_nxt;
      dcnt_r     <= dcnt_nxt;
      pidx_r     <= pidx_nxt;
    end
  end

  // Lanes
  logic signed [SAMPLE_BITS-1:0] re_a [NUM_FIELDS];
  logic signed [SAMPLE_BITS-1:0] im_a [NUM_FIELDS];
  logic signed [SAMPLE_BITS-1:0] mre_a [MAX_POLS];
  logic signed [SAMPLE_BITS-1:0] mim_a [MAX_POLS];
  logic [WEIGHT_W-1:0]           w_a   [MAX_POLS];

  assign re_a[0] = in_if.re_0;
  assign re_a[1] = in_if.re_1;
  assign re_a[2] = in_if.re_2;
  assign re_a[3] = in_if.re_3;
  assign im_a[0] = in_if.im_0;
  assign im_a[1] = in_if.im_1;
  assign im_a[2] = in_if.im_2;
  assign im_a[3] = in_if.im_3;

  for (genvar p = 0; p < MAX_POLS; p++) begin : g_lane
    fca_lane #(.MAX_STEP(MAX_STEP), .SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .en(en_mask[p]), .bad(bad_v[p]),
      .re(re_a[p]), .im(im_a[p]), .st(st),
      .mean_re(mre_a[p]), .mean_im(mim_a[p]), .weight(w_a[p]));
  end

  // Merge: present one lane per output transaction
  assign out_if.pol_index     = POL_IDX_W'(pidx_r);
  assign out_if.mean_re       = mre_a[pidx_r];
  assign out_if.mean_im       = mim_a[pidx_r];
  assign out_if.weight        = w_a[pidx_r];
  assign out_if.group_flagged = grp_flag_r;
  assign out_if.last_of_group = (32'(pidx_r) + 1 == 32'(np_r));
endmodule

// File: hdl/fca_div.sv
// Restoring unsigned divider, one quotient bit per step.
// Stand-alone; stepped by the lane.
module fca_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;

  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (step) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;
endmodule

// File: hdl/fca_lane.sv
// One polarisation lane: accumulates good samples and divides at group end.
// Depends on fca_pkg and fca_div.
module fca_lane
  import fca_pkg::*;
#(
  parameter int MAX_STEP    = DEF_MAX_STEP,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fca_lane_ctl_t                 ctl,
  input  logic                          en,
  input  logic                          bad,
  input  logic signed [SAMPLE_BITS-1:0] re,
  input  logic signed [SAMPLE_BITS-1:0] im,
  input  logic [$clog2(MAX_STEP+1)-1:0] st,
  output logic signed [SAMPLE_BITS-1:0] mean_re,
  output logic signed [SAMPLE_BITS-1:0] mean_im,
  output logic [WEIGHT_W-1:0]           weight
);
  localparam int GCW   = $clog2(MAX_STEP + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_STEP);
  localparam int NW    = (SUM_W > GCW + WEIGHT_W) ? SUM_W : GCW + WEIGHT_W;

  logic signed [SUM_W-1:0] sre_r, sre_nxt, sim_r, sim_nxt;
  logic [GCW-1:0]          cnt_r, cnt_nxt;
  logic                    neg_re_r, neg_im_r, zero_r;
  logic [SUM_W-1:0]        mag_re, mag_im;
  logic [GCW+WEIGHT_W-1:0] wnum;
  logic [NW-1:0]           q_re, q_im, q_w;
  logic [SAMPLE_BITS-1:0]  qs_re, qs_im;
  logic                    take;

  assign take = ctl.acc && en && !bad;

  always_comb begin
    sre_nxt = sre_r;
    sim_nxt = sim_r;
    cnt_nxt = cnt_r;
    if (take) begin
      sre_nxt = sre_r + SUM_W'(re);
      sim_nxt = sim_r + SUM_W'(im);
      cnt_nxt = cnt_r + GCW'(1);
    end
  end

  assign mag_re = sre_nxt[SUM_W-1] ? SUM_W'(-sre_nxt) : SUM_W'(sre_nxt);
  assign mag_im = sim_nxt[SUM_W-1] ? SUM_W'(-sim_nxt) : SUM_W'(sim_nxt);
  assign wnum   = {cnt_nxt, {WEIGHT_W{1'b0}}} - (GCW+WEIGHT_W)'(cnt_nxt);

  // Drop the group on clear or after its sums have gone to the dividers.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear || ctl.load) begin
      sre_r <= '0;
      sim_r <= '0;
      cnt_r <= '0;
    end else begin
      sre_r <= sre_nxt;
      sim_r <= sim_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg_re_r <= sre_nxt[SUM_W-1];
      neg_im_r <= sim_nxt[SUM_W-1];
      zero_r   <= (cnt_nxt == '0);
    end
  end

  fca_div #(.NUM_W(NW), .DEN_W(GCW)) u_div_re (
    .clk(clk), .load(ctl.load), .step(ctl.div_step),
    .num(NW'(mag_re)), .den(cnt_nxt), .quo(q_re));
  fca_div #(.NUM_W(NW), .DEN_W(GCW)) u_div_im (
    .clk(clk), .load(ctl.load), .step(ctl.div_step),
    .num(NW'(mag_im)), .den(cnt_nxt), .quo(q_im));
  fca_div #(.NUM_W(NW), .DEN_W(GCW)) u_div_w (
    .clk(clk), .load(ctl.load), .step(ctl.div_step),
    .num(NW'(wnum)), .den(st), .quo(q_w));

  assign qs_re = q_re[SAMPLE_BITS-1:0];
  assign qs_im = q_im[SAMPLE_BITS-1:0];

  always_comb begin
    if (zero_r) begin
      mean_re = '0;
      mean_im = '0;
      weight  = '0;
    end else begin
      mean_re = neg_re_r ? -$signed(qs_re) : $signed(qs_re);
      mean_im = neg_im_r ? -$signed(qs_im) : $signed(qs_im);
      weight  = (q_w > NW'({WEIGHT_W{1'b1}})) ? {WEIGHT_W{1'b1}} : q_w[WEIGHT_W-1:0];
    end
  end
endmodule

// File: hdl/fca_checker.sv
// Port-level checker for the flagged channel averager, bound to the top level.
// Depends on the ports of flagged_channel_averager only.
module fca_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] pol_index,
  input logic       last_of_group
);
  // Input stays blocked while results are pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input open while results pending");

  // Hold the result while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pol_index))
    else $error("result changed under stall");

  // A non-final result is followed by the next lane
  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_group |=>
      out_valid && pol_index == $past(pol_index) + 2'd1)
    else $error("lane sequence broken");

  // After the final result the block returns to taking input
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last_of_group |=> !out_valid && in_ready)
    else $error("group did not end");
endmodule

bind flagged_channel_averager fca_checker u_fca_checker (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .pol_index(out_if.pol_index), .last_of_group(out_if.last_of_group)
);
